FILE: rtl/wlfa_pkg.sv
// Package: shared widths, constants, payload types and state encodings of the fit accumulator.
package wlfa_pkg;

    // Default fraction bits of the log domain
    localparam int FRAC_BITS_DEF = 16;

    // Fixed field widths
    localparam int X_W    = 32;
    localparam int N_W    = 8;
    localparam int WT_W   = 17;
    localparam int MU_W   = 24;
    localparam int SG_W   = 23;

    // log2 unit: Q.30 result, 5 integer bits
    localparam int LOG_FRAC = 30;
    localparam int LOG_K_W  = 5;
    localparam int LOG_W    = LOG_K_W + LOG_FRAC;
    localparam int LOG_STEPS = LOG_FRAC;

    // ln2 in Q.28
    localparam int LN2_W = 28;
    localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065280;

    // Accumulator widths
    localparam int SUM_W  = 64;
    localparam int WTOT_W = 48;

    // Integer square root steps over a 64-bit radicand
    localparam int ROOT_STEPS = SUM_W / 2;

    // Depth of the queue between front and back
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [X_W-1:0]  intensity;
        logic [N_W-1:0]  dye_count;
        logic [WT_W-1:0] sample_weight;
    } t_sample;

    typedef struct packed {
        logic signed [MU_W-1:0] mu_estimate;
        logic [SG_W-1:0]        sigma_estimate;
        logic                   fit_valid;
        logic                   sample_used;
    } t_fit;

    // Queue entry: sample plus its classification
    typedef struct packed {
        t_sample smp;
        logic    used;
    } t_entry;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQUARE
    } t_log_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOG_X,
        B_LOG_N,
        B_SCALE,
        B_ROUND,
        B_SQUARE,
        B_WEIGHT,
        B_ACC,
        B_CHECK,
        B_DIV_MU,
        B_DIV_SQ,
        B_ROOT_INIT,
        B_ROOT,
        B_EMIT
    } t_back_state;

endpackage

FILE: rtl/wlfa_stream_if.sv
// Interface: valid/ready stream channel carrying one payload per transaction.
interface wlfa_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/wlfa_front.sv
// Front end: accepts samples, classifies them as used or skipped, and queues them.
module wlfa_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wlfa_stream_if.sink   i_smp,
    wlfa_stream_if.source o_q
);
    localparam int PW = $clog2(wlfa_pkg::QDEPTH);

    wlfa_pkg::t_entry r_mem [wlfa_pkg::QDEPTH];
    logic [PW-1:0]    r_wptr, r_rptr;
    logic [PW:0]      r_count;
    logic             push, pop;
    wlfa_pkg::t_entry entry;

    // Classification: skip when either x or n is zero
    always_comb begin
        entry.smp  = i_smp.data;
        entry.used = (|i_smp.data.intensity) && (|i_smp.data.dye_count);
    end

    assign i_smp.ready = (r_count != (PW+1)'(wlfa_pkg::QDEPTH));
    assign o_q.valid   = (r_count != '0);
    assign o_q.data    = r_mem[r_rptr];
    assign push        = i_smp.valid && i_smp.ready;
    assign pop         = o_q.valid && o_q.ready;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= entry;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

FILE: rtl/wlfa_log2.sv
// Iterative log2 unit: normalize, then one squaring step per cycle, Q.30 result.
module wlfa_log2 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wlfa_pkg::X_W-1:0]      i_value,
    output logic                          o_done,
    output logic [wlfa_pkg::LOG_W-1:0]    o_result
);
    localparam int CW = $clog2(wlfa_pkg::LOG_STEPS);

    wlfa_pkg::t_log_state             r_state, n_state;
    logic [31:0]                      r_y;
    logic [wlfa_pkg::LOG_K_W-1:0]     r_k;
    logic [wlfa_pkg::LOG_FRAC-1:0]    r_frac;
    logic [CW-1:0]                    r_cnt;
    logic                             r_done;
    logic [63:0]                      sq;
    logic [32:0]                      sq_sh;
    logic                             last;

    assign sq    = {32'd0, r_y} * {32'd0, r_y};
    assign sq_sh = sq[63:31];
    assign last  = (r_cnt == CW'(wlfa_pkg::LOG_STEPS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wlfa_pkg::LG_IDLE:   if (i_start) n_state = wlfa_pkg::LG_NORM;
            wlfa_pkg::LG_NORM:   if (r_y[31]) n_state = wlfa_pkg::LG_SQUARE;
            wlfa_pkg::LG_SQUARE: if (last) n_state = wlfa_pkg::LG_IDLE;
            default:             n_state = wlfa_pkg::LG_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_done   = r_done;
        o_result = {r_k, r_frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wlfa_pkg::LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == wlfa_pkg::LG_SQUARE) && last;
        end
    end

    // Datapath; the value is never zero here, so normalization ends
    always_ff @(posedge i_clk) begin
        case (r_state)
            wlfa_pkg::LG_IDLE: begin
                if (i_start) begin
                    r_y    <= i_value;
                    r_k    <= '1;
                    r_frac <= '0;
                    r_cnt  <= '0;
                end
            end
            wlfa_pkg::LG_NORM: begin
                if (r_y[31:24] == 8'd0) begin
                    r_y <= {r_y[23:0], 8'd0};
                    r_k <= r_k - wlfa_pkg::LOG_K_W'(8);
                end else if (!r_y[31]) begin
                    r_y <= {r_y[30:0], 1'b0};
                    r_k <= r_k - wlfa_pkg::LOG_K_W'(1);
                end
            end
            wlfa_pkg::LG_SQUARE: begin
                r_frac <= {r_frac[wlfa_pkg::LOG_FRAC-2:0], sq_sh[32]};
                r_y    <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
                r_cnt  <= r_cnt + CW'(1);
            end
            default: ;
        endcase
    end
endmodule

FILE: rtl/wlfa_div.sv
// Restoring divider: one quotient bit per cycle over the full numerator width.
module wlfa_div #(
    parameter int NW = 80
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [NW-1:0]                 i_num,
    input  logic [wlfa_pkg::WTOT_W-1:0]   i_den,
    output logic                          o_done,
    output logic [NW-1:0]                 o_quo,
    output logic [wlfa_pkg::WTOT_W-1:0]   o_rem
);
    localparam int CW = $clog2(NW);
    localparam int DW = wlfa_pkg::WTOT_W;

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem, r_den;
    logic [DW:0]   trial, diff;
    logic          ge;

    // One restoring step
    assign trial = {r_rem, r_q[NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(NW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(NW - 1))) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_cnt <= r_cnt + CW'(1);
        end
    end
endmodule

FILE: rtl/wlfa_back.sv
// Back end: log of the sample, saturating accumulation, mean, variance and root, output register.
module wlfa_back #(
    parameter int FRAC_BITS = wlfa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wlfa_stream_if.sink   i_q,
    wlfa_stream_if.source o_fit
);
    localparam int LW   = FRAC_BITS + 6;          // |ln| magnitude
    localparam int L2W  = FRAC_BITS + 13;         // rounded square
    localparam int SH   = wlfa_pkg::LOG_FRAC + wlfa_pkg::LN2_W - FRAC_BITS;
    localparam int PW   = wlfa_pkg::LOG_W + wlfa_pkg::LN2_W;
    localparam int WLW  = wlfa_pkg::WT_W + LW;
    localparam int WL2W = wlfa_pkg::WT_W + L2W;
    localparam int NW   = wlfa_pkg::SUM_W + FRAC_BITS;
    localparam int SW   = wlfa_pkg::SUM_W;
    localparam int TW   = wlfa_pkg::WTOT_W;
    localparam int MW   = wlfa_pkg::MU_W;
    localparam int RCW  = $clog2(wlfa_pkg::ROOT_STEPS);

    wlfa_pkg::t_back_state r_state, n_state;

    // Sample and intermediate registers
    logic [wlfa_pkg::N_W-1:0]  r_n;
    logic [wlfa_pkg::WT_W-1:0] r_w;
    logic                      r_used;
    logic [wlfa_pkg::LOG_W-1:0] r_a, r_b;
    logic                      r_neg;
    logic [PW-1:0]             r_lprod;
    logic [LW-1:0]             r_lmag;
    logic [2*LW-1:0]           r_sq;
    logic [WLW-1:0]            r_wl;
    logic [WL2W-1:0]           r_wl2;

    // Accumulators
    logic [SW-1:0]             r_sum, r_sqs;
    logic [TW-1:0]             r_wtot;

    // Fit registers
    logic                      r_fit_valid;
    logic [MW-1:0]             r_mu;
    logic [SW-1:0]             r_m2;
    logic [2*MW-1:0]           r_musq;
    logic [SW-1:0]             r_v, r_res, r_bit;
    logic [RCW-1:0]            r_rcnt;

    // Output register
    logic                      r_out_valid;
    wlfa_pkg::t_fit            r_out;

    // Unit handshakes
    logic                      log_start, log_done;
    logic [wlfa_pkg::X_W-1:0]  log_val;
    logic [wlfa_pkg::LOG_W-1:0] log_res;
    logic                      div_start, div_done;
    logic [NW-1:0]             div_num, div_quo;
    logic [TW-1:0]             div_rem;
    logic                      emit_load, take;

    wlfa_log2 u_log2 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (log_start),
        .i_value  (log_val),
        .o_done   (log_done),
        .o_result (log_res)
    );

    wlfa_div #(.NW(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_wtot),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // Log difference and its scaling
    logic [wlfa_pkg::LOG_W-1:0] dmag;
    logic [SW-1:0]              lsum;
    logic [2*LW:0]              s2;
    logic [L2W-1:0]             l2;

    always_comb begin
        dmag = (r_b > r_a) ? (r_b - r_a) : (r_a - r_b);
        lsum = {{(SW-PW){1'b0}}, r_lprod} + (SW'(1) << (SH - 1));
        s2   = {1'b0, r_sq} + ((2*LW+1)'(1) << (FRAC_BITS - 1));
        l2   = s2[2*LW:FRAC_BITS];
    end

    // Saturating accumulator updates
    logic [SW:0]   sum_nx, sqs_nx;
    logic [TW:0]   wtot_nx;

    always_comb begin
        sum_nx  = r_neg ? ({r_sum[SW-1], r_sum} - (SW+1)'(r_wl))
                        : ({r_sum[SW-1], r_sum} + (SW+1)'(r_wl));
        sqs_nx  = {1'b0, r_sqs} + (SW+1)'(r_wl2);
        wtot_nx = {1'b0, r_wtot} + (TW+1)'(r_w);
    end

    // Mean rounding and saturation
    logic [SW-1:0] smag;
    logic [TW-1:0] half;
    logic [NW-1:0] qr;
    logic [MW-1:0] mu_nx, mu_mag;
    logic [SW-1:0] m2_nx;

    always_comb begin
        smag   = r_sum[SW-1] ? (SW'(0) - r_sum) : r_sum;
        half   = r_wtot - (r_wtot >> 1);
        qr     = div_quo + NW'(div_rem >= half);
        if (r_sum[SW-1]) begin
            mu_nx = (qr > (NW'(1) << (MW - 1))) ? {1'b1, {(MW-1){1'b0}}}
                                                : (MW'(0) - qr[MW-1:0]);
        end else begin
            mu_nx = (qr > NW'({1'b0, {(MW-1){1'b1}}})) ? {1'b0, {(MW-1){1'b1}}}
                                                       : qr[MW-1:0];
        end
        mu_mag = r_mu[MW-1] ? (MW'(0) - r_mu) : r_mu;
        m2_nx  = (|div_quo[NW-1:SW]) ? '1 : div_quo[SW-1:0];
    end

    // Root step
    logic [SW-1:0] rtry;
    logic          rge;

    assign rtry = r_res + r_bit;
    assign rge  = (r_v >= rtry);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wlfa_pkg::B_IDLE:
                if (i_q.valid) n_state = i_q.data.used ? wlfa_pkg::B_LOG_X : wlfa_pkg::B_CHECK;
            wlfa_pkg::B_LOG_X:     if (log_done) n_state = wlfa_pkg::B_LOG_N;
            wlfa_pkg::B_LOG_N:     if (log_done) n_state = wlfa_pkg::B_SCALE;
            wlfa_pkg::B_SCALE:     n_state = wlfa_pkg::B_ROUND;
            wlfa_pkg::B_ROUND:     n_state = wlfa_pkg::B_SQUARE;
            wlfa_pkg::B_SQUARE:    n_state = wlfa_pkg::B_WEIGHT;
            wlfa_pkg::B_WEIGHT:    n_state = wlfa_pkg::B_ACC;
            wlfa_pkg::B_ACC:       n_state = wlfa_pkg::B_CHECK;
            wlfa_pkg::B_CHECK:
                n_state = (r_wtot != '0) ? wlfa_pkg::B_DIV_MU : wlfa_pkg::B_EMIT;
            wlfa_pkg::B_DIV_MU:    if (div_done) n_state = wlfa_pkg::B_DIV_SQ;
            wlfa_pkg::B_DIV_SQ:    if (div_done) n_state = wlfa_pkg::B_ROOT_INIT;
            wlfa_pkg::B_ROOT_INIT: n_state = wlfa_pkg::B_ROOT;
            wlfa_pkg::B_ROOT:
                if (r_rcnt == RCW'(wlfa_pkg::ROOT_STEPS - 1)) n_state = wlfa_pkg::B_EMIT;
            wlfa_pkg::B_EMIT:      if (emit_load) n_state = wlfa_pkg::B_IDLE;
            default:               n_state = wlfa_pkg::B_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        i_q.ready = (r_state == wlfa_pkg::B_IDLE);
        take      = i_q.valid && (r_state == wlfa_pkg::B_IDLE);
        log_start = (take && i_q.data.used) || ((r_state == wlfa_pkg::B_LOG_X) && log_done);
        log_val   = (r_state == wlfa_pkg::B_IDLE) ? i_q.data.smp.intensity
                                                  : wlfa_pkg::X_W'(r_n);
        div_start = ((r_state == wlfa_pkg::B_CHECK) && (r_wtot != '0))
                 || ((r_state == wlfa_pkg::B_DIV_MU) && div_done);
        div_num   = (r_state == wlfa_pkg::B_CHECK) ? NW'(smag)
                                                   : {r_sqs, {FRAC_BITS{1'b0}}};
        emit_load = (r_state == wlfa_pkg::B_EMIT) && (!r_out_valid || o_fit.ready);
    end

    assign o_fit.valid = r_out_valid;
    assign o_fit.data  = r_out;

    // Control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wlfa_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_sqs       <= '0;
            r_wtot      <= '0;
        end else begin
            r_state <= n_state;
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (o_fit.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == wlfa_pkg::B_ACC) begin
                if (sum_nx[SW] != sum_nx[SW-1]) begin
                    r_sum <= {sum_nx[SW], {(SW-1){~sum_nx[SW]}}};
                end else begin
                    r_sum <= sum_nx[SW-1:0];
                end
                r_sqs  <= sqs_nx[SW] ? '1 : sqs_nx[SW-1:0];
                r_wtot <= wtot_nx[TW] ? '1 : wtot_nx[TW-1:0];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            wlfa_pkg::B_IDLE: begin
                if (take) begin
                    r_n    <= i_q.data.smp.dye_count;
                    r_w    <= i_q.data.smp.sample_weight;
                    r_used <= i_q.data.used;
                end
            end
            wlfa_pkg::B_LOG_X: if (log_done) r_a <= log_res;
            wlfa_pkg::B_LOG_N:
                if (log_done) r_b <= log_res + (wlfa_pkg::LOG_W'(16) << wlfa_pkg::LOG_FRAC);
            wlfa_pkg::B_SCALE: begin
                r_neg   <= (r_b > r_a);
                r_lprod <= PW'(dmag) * PW'(wlfa_pkg::LN2_Q28);
            end
            wlfa_pkg::B_ROUND:  r_lmag <= lsum[SW-1:SH];
            wlfa_pkg::B_SQUARE: begin
                r_sq <= (2*LW)'(r_lmag) * (2*LW)'(r_lmag);
                r_wl <= WLW'(r_w) * WLW'(r_lmag);
            end
            wlfa_pkg::B_WEIGHT: r_wl2 <= WL2W'(r_w) * WL2W'(l2);
            wlfa_pkg::B_CHECK:  r_fit_valid <= (r_wtot != '0);
            wlfa_pkg::B_DIV_MU: if (div_done) r_mu <= mu_nx;
            wlfa_pkg::B_DIV_SQ: begin
                if (div_done) begin
                    r_m2   <= m2_nx;
                    r_musq <= (2*MW)'(mu_mag) * (2*MW)'(mu_mag);
                end
            end
            wlfa_pkg::B_ROOT_INIT: begin
                r_v    <= (r_m2 > SW'(r_musq)) ? (r_m2 - SW'(r_musq)) : '0;
                r_res  <= '0;
                r_bit  <= SW'(1) << (SW - 2);
                r_rcnt <= '0;
            end
            wlfa_pkg::B_ROOT: begin
                if (rge) begin
                    r_v   <= r_v - rtry;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit  <= r_bit >> 2;
                r_rcnt <= r_rcnt + RCW'(1);
            end
            wlfa_pkg::B_EMIT: begin
                if (emit_load) begin
                    r_out.sample_used <= r_used;
                    r_out.fit_valid   <= r_fit_valid;
                    r_out.mu_estimate <= r_fit_valid ? r_mu : '0;
                    if (!r_fit_valid) begin
                        r_out.sigma_estimate <= '0;
                    end else if (|r_res[SW-1:wlfa_pkg::SG_W]) begin
                        r_out.sigma_estimate <= '1;
                    end else begin
                        r_out.sigma_estimate <= r_res[wlfa_pkg::SG_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

FILE: rtl/weighted_lognormal_fit_accumulator_top.sv
// Top level: one sample in per transaction, one fit estimate out per sample.
// A skipped sample with a nonzero total weight goes through the divider and the root; an
// accumulated one first takes two log2 runs; an empty fit goes straight to the output
// register. Throughput: one sample per back-end pass, which waits on the output handshake and
// is set by the shared bit-serial divider (two passes) and the 32-step root.
// Reset (synchronous, active low) clears the sums, the total weight, queue and handshakes.
module weighted_lognormal_fit_accumulator_top #(
    parameter int FRAC_BITS = wlfa_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wlfa_stream_if.sink   i_smp,
    wlfa_stream_if.source o_fit
);
    wlfa_stream_if #(.T(wlfa_pkg::t_entry)) u_q ();

    wlfa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .o_q     (u_q)
    );

    wlfa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (u_q),
        .o_fit   (o_fit)
    );
endmodule

FILE: tb/tb.sv
// Testbench: drives samples into the fit accumulator and checks every fit estimate.
module tb;
    localparam int FRAC = wlfa_pkg::FRAC_BITS_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam logic [63:0] U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] WTOT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] LN2 = 64'd186065280;

    logic i_clk;
    logic i_rst_n;

    wlfa_stream_if #(.T(wlfa_pkg::t_sample)) smp_if ();
    wlfa_stream_if #(.T(wlfa_pkg::t_fit))    fit_if ();

    weighted_lognormal_fit_accumulator_top #(.FRAC_BITS(FRAC)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_smp  (smp_if.sink),
        .o_fit  (fit_if.source)
    );

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow copy of the accumulators
    logic signed [63:0] log_sum;
    logic [63:0]        log_sq_sum;
    logic [47:0]        wt_total;

    wlfa_pkg::t_fit fit_queue[$];
    int   mismatches;
    int   fits_seen;
    int   used_seen;
    int   empty_seen;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   idle_cycles;
    bit   timed_out;

    // log2 of m (m > 0) in Q.30 by repeated squaring
    function automatic logic [63:0] log2_q30(input logic [31:0] m);
        int          k;
        logic [63:0] y;
        logic [63:0] frac;
        k = 31;
        frac = '0;
        while (k > 0 && m[k] == 1'b0) k--;
        y = 64'(m) << (31 - k);
        for (int i = 0; i < wlfa_pkg::LOG_FRAC; i++) begin
            y = (y * y) >> 31;
            frac = frac << 1;
            if (y >= 64'h1_0000_0000) begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(k) << wlfa_pkg::LOG_FRAC) | frac;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // floor(num * 2^FRAC / den), saturating
    function automatic logic [63:0] scaled_quotient(input logic [63:0] num,
                                                    input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        logic        sat;
        q = num / den;
        r = num % den;
        sat = 1'b0;
        for (int i = 0; i < FRAC; i++) begin
            if (q[63]) sat = 1'b1;
            // remainder stays below den < 2^48, so no overflow on shift
            r = r << 1;
            q = (q << 1) | 64'(r >= den);
            if (r >= den) r = r - den;
        end
        return sat ? U64_MAX : q;
    endfunction

    // Update the shadow sums with one sample and return the expected fit
    function automatic wlfa_pkg::t_fit predict_fit(input wlfa_pkg::t_sample s);
        wlfa_pkg::t_fit f;
        logic [63:0]   a, b, dmag, lmag, l2, wl, wl2, w;
        logic [63:0]   smag, q, m2, musq, rad, sg;
        logic [127:0]  prod;
        logic [48:0]   wsum;
        logic          neg, sneg;
        logic signed [63:0] mu;
        f = '0;
        mu = 0;
        w = 64'(s.sample_weight);
        if (s.dye_count != 0 && s.intensity != 0) begin
            a = log2_q30(s.intensity);
            b = log2_q30(32'(s.dye_count)) + (64'd16 << wlfa_pkg::LOG_FRAC);
            neg = b > a;
            dmag = neg ? b - a : a - b;
            prod = 128'(dmag) * 128'(LN2)
                 + (128'd1 << (wlfa_pkg::LOG_FRAC + 28 - FRAC - 1));
            lmag = 64'(prod >> (wlfa_pkg::LOG_FRAC + 28 - FRAC));
            l2 = (lmag * lmag + (64'd1 << (FRAC - 1))) >> FRAC;
            wl = w * lmag;
            wl2 = w * l2;
            if (neg) begin
                if (log_sum < $signed(64'h8000_0000_0000_0000 + wl))
                    log_sum = 64'sh8000_0000_0000_0000;
                else
                    log_sum = log_sum - $signed(wl);
            end else begin
                if (log_sum > $signed(64'h7FFF_FFFF_FFFF_FFFF - wl))
                    log_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
                else
                    log_sum = log_sum + $signed(wl);
            end
            if (log_sq_sum > U64_MAX - wl2) log_sq_sum = U64_MAX;
            else log_sq_sum = log_sq_sum + wl2;
            wsum = 49'(wt_total) + 49'(s.sample_weight);
            wt_total = wsum[48] ? WTOT_MAX : wsum[47:0];
            f.sample_used = 1'b1;
        end
        if (wt_total != 0) begin
            sneg = log_sum < 0;
            smag = sneg ? 64'd0 - 64'(log_sum) : 64'(log_sum);
            q = smag / 64'(wt_total);
            if (smag % 64'(wt_total) >= 64'(wt_total) - 64'(wt_total) / 2) q++;
            if (sneg) mu = (q > 64'd8388608) ? -64'sd8388608 : -$signed(q);
            else mu = (q > 64'd8388607) ? 64'sd8388607 : $signed(q);
            m2 = scaled_quotient(log_sq_sum, 64'(wt_total));
            musq = 64'(mu < 0 ? -mu : mu);
            musq = musq * musq;
            rad = m2 > musq ? m2 - musq : 64'd0;
            sg = floor_sqrt(rad);
            if (sg > 64'd8388607) sg = 64'd8388607;
            f.mu_estimate = mu[wlfa_pkg::MU_W-1:0];
            f.sigma_estimate = sg[wlfa_pkg::SG_W-1:0];
            f.fit_valid = 1'b1;
        end
        return f;
    endfunction

    // Send one sample, with random idle cycles before it; valid stays up for a
    // following sample and is dropped by the idle loop or by wait_drained
    task automatic send_sample(input logic [31:0] x, input logic [7:0] n,
                               input logic [16:0] w);
        wlfa_pkg::t_sample s;
        s.intensity = x;
        s.dye_count = n;
        s.sample_weight = w;
        while ($urandom_range(99) < sender_idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.data <= s;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        fit_queue.push_back(predict_fit(s));
    endtask

    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        while (fit_queue.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    // Directed: empty fit, skips, extremes of every field, zero and big weights
    task automatic test_directed();
        send_sample(32'd0, 8'd0, 17'd0);
        send_sample(32'd0, 8'd5, 17'd65536);
        send_sample(32'd100, 8'd0, 17'd65536);
        send_sample(32'h0001_0000, 8'd1, 17'd0);
        send_sample(32'h0001_0000, 8'd1, 17'd65536);
        send_sample(32'hFFFF_FFFF, 8'd1, 17'd65536);
        send_sample(32'd1, 8'd255, 17'd65536);
        send_sample(32'd1, 8'd1, 17'd1);
        send_sample(32'hFFFF_FFFF, 8'd255, 17'h1FFFF);
        send_sample(32'h0002_0000, 8'd2, 17'd32768);
        send_sample(32'h8000_0000, 8'h80, 17'h10000);
        send_sample(32'h5555_5555, 8'h55, 17'h0AAAA);
        send_sample(32'hAAAA_AAAA, 8'hAA, 17'h15555);
        send_sample(32'h0003_0000, 8'd3, 17'd65536);
        send_sample(32'h0003_0000, 8'd3, 17'd65536);
        send_sample(32'd0, 8'd255, 17'h1FFFF);
    endtask

    // Random samples: mostly well formed, some skips and odd weights
    task automatic test_random(input int count);
        logic [31:0] x;
        logic [7:0]  n;
        logic [16:0] w;
        for (int i = 0; i < count; i++) begin
            n = 8'($urandom_range(255, 1));
            case ($urandom_range(9))
                0: x = $urandom;
                1: x = 32'($urandom_range(255));
                2: x = 32'h0001_0000 * n + 32'($urandom_range(4096));
                default: x = 32'(n) * 32'($urandom_range(32'h0100_0000, 32'h0000_1000));
            endcase
            case ($urandom_range(9))
                0: w = 17'($urandom);
                1: w = 17'd0;
                2: w = 17'($urandom_range(65536, 65000));
                default: w = 17'($urandom_range(65536));
            endcase
            if ($urandom_range(19) == 0) n = 8'd0;
            if ($urandom_range(29) == 0) x = 32'd0;
            send_sample(x, n, w);
        end
    endtask

    // Sender holds off until the pipeline is empty, then goes on
    task automatic test_drain_pause();
        send_sample(32'h0004_0000, 8'd1, 17'd65536);
        wait_drained();
        send_sample(32'h0000_4000, 8'd1, 17'd65536);
        wait_drained();
    endtask

    // Receiver side: random stalls and result checks
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fit_if.ready <= 1'b0;
        end else begin
            fit_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
            if (fit_if.valid && fit_if.ready) begin
                fits_seen++;
                if (fit_if.data.sample_used) used_seen++;
                if (!fit_if.data.fit_valid) empty_seen++;
                if (fit_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected fit transaction: %p", fit_if.data);
                end else begin
                    wlfa_pkg::t_fit exp_fit;
                    exp_fit = fit_queue.pop_front();
                    if (fit_if.data !== exp_fit) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"fit mismatch #%0d: exp mu=%0d sg=%0d v=%b u=%b,",
                                " got mu=%0d sg=%0d v=%b u=%b"},
                                fits_seen, exp_fit.mu_estimate, exp_fit.sigma_estimate,
                                exp_fit.fit_valid, exp_fit.sample_used,
                                fit_if.data.mu_estimate, fit_if.data.sigma_estimate,
                                fit_if.data.fit_valid, fit_if.data.sample_used);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (fit_if.valid && fit_if.ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("watchdog expired, %0d fits outstanding", fit_queue.size());
            $display("FAIL weighted_lognormal_fit_accumulator_top");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        smp_if.valid = 1'b0;
        smp_if.data = '0;
        log_sum = '0;
        log_sq_sum = '0;
        wt_total = '0;
        mismatches = 0;
        fits_seen = 0;
        used_seen = 0;
        empty_seen = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        sender_idle_pct = 10;
        receiver_idle_pct = 48;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_pause();
        test_random(250);
        sender_idle_pct = 48;
        receiver_idle_pct = 10;
        test_random(250);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random(230);

        wait_drained();
        repeat (400) @(posedge i_clk);
        $display("Covered %0d fits: %0d accumulated samples, %0d empty fits,",
            fits_seen, used_seen, empty_seen);
        $display("  with skipped, zero-weight, over-unity and extreme samples.");
        if (mismatches == 0 && fit_queue.size() == 0) begin
            $display("PASS weighted_lognormal_fit_accumulator_top");
        end else begin
            $display("%0d mismatches, %0d fits missing", mismatches, fit_queue.size());
            $display("FAIL weighted_lognormal_fit_accumulator_top");
        end
        $finish;
    end
endmodule
